// ----- hw/rtl/thcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heading fusion package
// Shared widths, constants, the CORDIC arctangent table and helper functions.
// ----------------------------------------------------------------------------
package thcf_pkg;

   // CORDIC datapath width and angle width (angles in 1/65536 degree).
   localparam int DW = 56;
   localparam int ZW = 26;
   localparam int TAB_LEN = 24;

   // CORDIC start value for rotation mode, 0.6072529350 in Q2.30.
   localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
   // Gyro scale 0.007813e-3 in Q40.
   localparam logic [23:0] GYRO_K = 24'd8590484;
   // Ninety degrees in 1/65536 degree.
   localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd5898240;

   typedef struct packed {
      logic start;
      logic vector_mode;
   } cord_ctl_type;

   // round(atan(2^-i) * 65536), in degrees.
   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Clamp a wide value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/thcf_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Vectoring mode gives atan2(y, x); rotation mode gives cos and sin in Q2.30.
// ----------------------------------------------------------------------------
module thcf_cordic #(
   parameter int ITERATIONS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire thcf_pkg::cord_ctl_type           ctl,
   input  wire logic signed [thcf_pkg::DW-1:0]   x_in,
   input  wire logic signed [thcf_pkg::DW-1:0]   y_in,
   input  wire logic signed [thcf_pkg::ZW-1:0]   z_in,
   output logic                                  done,
   output logic signed [thcf_pkg::DW-1:0]        x_out,
   output logic signed [thcf_pkg::DW-1:0]        y_out,
   output logic signed [thcf_pkg::ZW-1:0]        z_out
);
   import thcf_pkg::*;

   localparam int NITER = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
   localparam logic signed [DW-1:0] LIM = DW'(64'sd1 <<< 40);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_NORM = 3'b010,
      C_ITER = 3'b100
   } cstate_type;

   cstate_type state_ff, state_in;
   logic signed [DW-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [ZW-1:0] z_ff, z_in_nx;
   logic [4:0] iter_ff, iter_in;
   logic mode_ff, mode_in;
   logic done_ff, done_in;

   logic signed [DW-1:0] ax, ay, xs, ys;
   logic signed [ZW-1:0] at;

   assign ax = x_ff[DW-1] ? -x_ff : x_ff;
   assign ay = y_ff[DW-1] ? -y_ff : y_ff;
   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign at = atan_entry(iter_ff);

   always_comb begin
      state_in = state_ff;
      x_in_nx  = x_ff;
      y_in_nx  = y_ff;
      z_in_nx  = z_ff;
      iter_in  = iter_ff;
      mode_in  = mode_ff;
      done_in  = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               mode_in = ctl.vector_mode;
               iter_in = '0;
               if (ctl.vector_mode) begin
                  x_in_nx = x_in;
                  y_in_nx = y_in;
                  z_in_nx = '0;
                  if (x_in == '0 && y_in == '0) begin
                     done_in = 1'b1;
                  end else begin
                     state_in = C_NORM;
                  end
               end else begin
                  x_in_nx  = DW'(INV_GAIN);
                  y_in_nx  = '0;
                  z_in_nx  = z_in;
                  state_in = C_ITER;
               end
            end
         end
         C_NORM: begin
            // Scale small vectors up so the shifts keep enough bits.
            if (ax < LIM && ay < LIM) begin
               x_in_nx = x_ff <<< 1;
               y_in_nx = y_ff <<< 1;
            end else begin
               if (x_ff[DW-1]) begin
                  if (!y_ff[DW-1]) begin
                     x_in_nx = y_ff;
                     y_in_nx = -x_ff;
                     z_in_nx = QUARTER_TURN;
                  end else begin
                     x_in_nx = -y_ff;
                     y_in_nx = x_ff;
                     z_in_nx = -QUARTER_TURN;
                  end
               end
               state_in = C_ITER;
            end
         end
         C_ITER: begin
            if (mode_ff) begin
               if (!y_ff[DW-1]) begin
                  x_in_nx = x_ff + ys;
                  y_in_nx = y_ff - xs;
                  z_in_nx = z_ff + at;
               end else begin
                  x_in_nx = x_ff - ys;
                  y_in_nx = y_ff + xs;
                  z_in_nx = z_ff - at;
               end
            end else begin
               if (!z_ff[ZW-1]) begin
                  x_in_nx = x_ff - ys;
                  y_in_nx = y_ff + xs;
                  z_in_nx = z_ff - at;
               end else begin
                  x_in_nx = x_ff + ys;
                  y_in_nx = y_ff - xs;
                  z_in_nx = z_ff + at;
               end
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(NITER - 1)) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         iter_ff  <= '0;
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         iter_ff  <= iter_in;
         mode_ff  <= mode_in;
      end
      x_ff <= x_in_nx;
      y_ff <= y_in_nx;
      z_ff <= z_in_nx;
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == C_IDLE)
      else $error("cordic done while busy");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == C_ITER |-> iter_ff < 5'(NITER))
      else $error("cordic iteration count out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == C_IDLE)
      else $error("cordic started while busy");

endmodule
`default_nettype wire

// ----- hw/rtl/tilt_compensated_heading_fusion_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt-compensated heading fusion unit
// Compass heading from gravity and field vectors, gyro integration and a
// complementary filter, all sequenced over one CORDIC and one multiplier.
// ----------------------------------------------------------------------------
// The time from acceptance to result is set mostly by the three vectoring CORDIC
// passes and by their pre-scaling, which doubles small vectors step by step.
// One request is handled at a time; the next is taken once the previous result
// has been loaded into the output register.
// Reset clears both heading accumulators and loads the default offsets and
// blend weight. There is no clearing pass.
module tilt_compensated_heading_fusion_unit #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int ANGLE_FRAC_BITS   = 7
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z, gyro_z, elapsed_ms
   input  wire logic [127:0] req_tdata,
   // seed_heading
   input  wire logic         req_tuser,
   // Result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // compass_heading[15:0], fused_heading[39:16], gyro_heading[63:40]
   output logic [63:0]       rsp_tdata,
   // Configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import thcf_pkg::*;

   // Heading width: holds 360 degrees plus a sign.
   localparam int HW = $clog2(360 << ANGLE_FRAC_BITS) + 1;
   localparam logic signed [HW-1:0] FULL = HW'(360 << ANGLE_FRAC_BITS);
   // Shift that takes the Q40 gyro product down to accumulator units.
   localparam int GS = 32 - ANGLE_FRAC_BITS;
   // Multiplier operand width.
   localparam int MW = 38;

   typedef enum logic [1:0] {
      REG_OFF_X = 2'd0,
      REG_OFF_Y = 2'd1,
      REG_OFF_Z = 2'd2,
      REG_BLEND = 2'd3
   } reg_index_type;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MUL    = 7'b0000010,
      S_SQRT   = 7'b0000100,
      S_CSTART = 7'b0001000,
      S_CWAIT  = 7'b0010000,
      S_HCALC  = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      OP_ROLL     = 3'd0,
      OP_PITCH    = 3'd1,
      OP_SC_PITCH = 3'd2,
      OP_SC_ROLL  = 3'd3,
      OP_HEAD     = 3'd4
   } cord_op_type;

   // Multiply program: each step has a product phase, which registers the product, then an apply phase.
   typedef enum logic [3:0] {
      M_AYY  = 4'd0,
      M_AZZ  = 4'd1,
      M_SRSP = 4'd2,
      M_SRCP = 4'd3,
      M_BX0  = 4'd4,
      M_BX1  = 4'd5,
      M_BY0  = 4'd6,
      M_BY1  = 4'd7,
      M_BY2  = 4'd8,
      M_GMS  = 4'd9,
      M_GK   = 4'd10,
      M_FW   = 4'd11,
      M_FH   = 4'd12
   } mul_step_type;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_SUB  = 2'd2
   } mul_act_type;

   // Configuration registers.
   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;
   logic [15:0]        blend_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= -16'sd679;
         off_y_ff <= -16'sd541;
         off_z_ff <= -16'sd517;
         blend_ff <= 16'd64225;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_OFF_X: off_x_ff <= csr_pwdata[15:0];
            REG_OFF_Y: off_y_ff <= csr_pwdata[15:0];
            REG_OFF_Z: off_z_ff <= csr_pwdata[15:0];
            REG_BLEND: blend_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_OFF_X: csr_prdata = 32'(off_x_ff);
         REG_OFF_Y: csr_prdata = 32'(off_y_ff);
         REG_OFF_Z: csr_prdata = 32'(off_z_ff);
         REG_BLEND: csr_prdata = {16'b0, blend_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Sequencer state and working registers.
   state_type    state_ff, state_in;
   cord_op_type  cop_ff, cop_in;
   mul_step_type mstep_ff, mstep_in;
   logic         phase_ff, phase_in;

   logic signed [15:0] ax_ff, az_ff, gz_ff;
   logic signed [16:0] ayn_ff;
   logic signed [17:0] mx_ff, my_ff, mz_ff;
   logic [15:0]        ms_ff;
   logic               seed_ff;

   logic signed [63:0] prod_ff, acc_ff, acc_in;
   logic [47:0]        sqn_ff, sqn_in, res_ff, res_in, bit_ff, bit_in;
   logic [23:0]        r_ff, r_in;
   logic signed [ZW-1:0] roll_ff, roll_in, pitch_ff, pitch_in, hq_ff, hq_in;
   logic signed [31:0] cp_ff, cp_in, sp_ff, sp_in, cr_ff, cr_in, sr_ff, sr_in;
   logic signed [31:0] ssp_ff, ssp_in, scp_ff, scp_in;
   logic signed [DW-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [HW-1:0] h_ff, h_in;
   logic signed [MW-1:0] d_ff, d_in;
   logic signed [31:0] fz_ff, fz_in;
   logic signed [31:0] gacc_ff, gacc_in, facc_ff, facc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Shared CORDIC.
   cord_ctl_type         cctl;
   logic                 cdone;
   logic signed [DW-1:0] cx_in, cy_in, cx_out, cy_out;
   logic signed [ZW-1:0] cz_in, cz_out;

   always_comb begin
      cx_in = '0;
      cy_in = '0;
      cz_in = '0;
      cctl.vector_mode = 1'b1;
      case (cop_ff)
         OP_ROLL: begin
            cx_in = az_ff[15] ? -DW'(az_ff) : DW'(az_ff);
            cy_in = DW'(ayn_ff);
         end
         OP_PITCH: begin
            cx_in = DW'(signed'({1'b0, r_ff}));
            cy_in = -(DW'(ax_ff) <<< 8);
         end
         OP_SC_PITCH: begin
            cctl.vector_mode = 1'b0;
            cz_in = pitch_ff;
         end
         OP_SC_ROLL: begin
            cctl.vector_mode = 1'b0;
            cz_in = roll_ff;
         end
         OP_HEAD: begin
            cx_in = bx_ff;
            cy_in = -by_ff;
         end
         default: begin
         end
      endcase
      cctl.start = (state_ff == S_CSTART);
   end

   thcf_cordic #(
      .ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl   (cctl),
      .x_in  (cx_in),
      .y_in  (cy_in),
      .z_in  (cz_in),
      .done  (cdone),
      .x_out (cx_out),
      .y_out (cy_out),
      .z_out (cz_out)
   );

   // Shared multiplier with its operand selection.
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod_full;
   mul_act_type            mact;
   logic [16:0]            wc;

   assign wc = 17'h10000 - {1'b0, blend_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mact  = ACT_LOAD;
      case (mstep_ff)
         M_AYY: begin
            mul_a = MW'(ayn_ff);
            mul_b = MW'(ayn_ff);
         end
         M_AZZ: begin
            mul_a = MW'(az_ff);
            mul_b = MW'(az_ff);
            mact  = ACT_ADD;
         end
         M_SRSP: begin
            mul_a = MW'(sr_ff);
            mul_b = MW'(sp_ff);
         end
         M_SRCP: begin
            mul_a = MW'(sr_ff);
            mul_b = MW'(cp_ff);
         end
         M_BX0: begin
            mul_a = MW'(mx_ff);
            mul_b = MW'(cp_ff);
         end
         M_BX1: begin
            mul_a = MW'(mz_ff);
            mul_b = MW'(sp_ff);
            mact  = ACT_ADD;
         end
         M_BY0: begin
            mul_a = MW'(mx_ff);
            mul_b = MW'(ssp_ff);
         end
         M_BY1: begin
            mul_a = MW'(my_ff);
            mul_b = MW'(cr_ff);
            mact  = ACT_ADD;
         end
         M_BY2: begin
            mul_a = MW'(mz_ff);
            mul_b = MW'(scp_ff);
            mact  = ACT_SUB;
         end
         M_GMS: begin
            mul_a = -MW'(gz_ff);
            mul_b = MW'(signed'({1'b0, ms_ff}));
         end
         M_GK: begin
            mul_a = acc_ff[MW-1:0];
            mul_b = MW'(signed'({1'b0, GYRO_K}));
         end
         M_FW: begin
            mul_a = MW'(signed'({1'b0, blend_ff}));
            mul_b = MW'(facc_ff) + d_ff;
         end
         M_FH: begin
            mul_a = MW'(signed'({1'b0, wc}));
            mul_b = MW'(h_ff) <<< 8;
            mact  = ACT_ADD;
         end
         default: begin
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;

   // Main sequencer.
   always_comb begin
      logic signed [63:0] dsum;
      logic signed [63:0] fsum;
      logic [47:0]        trial;
      logic signed [ZW:0] hsum;
      logic signed [ZW:0] hrnd;
      logic signed [HW-1:0] hv;

      state_in     = state_ff;
      cop_in       = cop_ff;
      mstep_in     = mstep_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      sqn_in       = sqn_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      r_in         = r_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      hq_in        = hq_ff;
      cp_in        = cp_ff;
      sp_in        = sp_ff;
      cr_in        = cr_ff;
      sr_in        = sr_ff;
      ssp_in       = ssp_ff;
      scp_in       = scp_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      fz_in        = fz_ff;
      gacc_in      = gacc_ff;
      facc_in      = facc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (mact)
         ACT_ADD: dsum = acc_ff + prod_ff;
         ACT_SUB: dsum = acc_ff - prod_ff;
         default: dsum = prod_ff;
      endcase
      fsum  = (dsum + 64'sd32768) >>> 16;
      trial = res_ff + bit_ff;
      hsum  = (ZW+1)'(hq_ff) + ((ZW+1)'(1) <<< (15 - ANGLE_FRAC_BITS));
      hrnd  = hsum >>> (16 - ANGLE_FRAC_BITS);
      hv    = HW'(hrnd);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
               mstep_in = M_AYY;
               phase_in = 1'b0;
            end
         end
         S_MUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_in   = dsum;
               mstep_in = mul_step_type'(mstep_ff + 4'd1);
               case (mstep_ff)
                  M_AZZ: begin
                     // Radicand is (Y*Y + Z*Z) * 65536.
                     sqn_in   = {dsum[31:0], 16'b0};
                     res_in   = '0;
                     bit_in   = 48'd1 << 46;
                     state_in = S_SQRT;
                  end
                  M_SRSP: ssp_in = 32'(dsum >>> 30);
                  M_SRCP: scp_in = 32'(dsum >>> 30);
                  M_BX1:  bx_in  = DW'(dsum);
                  M_BY2: begin
                     by_in = DW'(dsum);
                     // A zero field vector gives a zero heading.
                     if (mx_ff == '0 && my_ff == '0 && mz_ff == '0) begin
                        hq_in    = '0;
                        state_in = S_HCALC;
                     end else begin
                        cop_in   = OP_HEAD;
                        state_in = S_CSTART;
                     end
                  end
                  M_GK: begin
                     // The product already carries the negated gyro rate.
                     d_in = MW'((dsum + (64'sd1 <<< (GS - 1))) >>> GS);
                  end
                  M_FH: begin
                     fz_in    = sat32(fsum);
                     state_in = S_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SQRT: begin
            // One result bit per cycle.
            if (sqn_ff >= trial) begin
               sqn_in = sqn_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               r_in     = res_in[23:0];
               cop_in   = OP_ROLL;
               state_in = S_CSTART;
            end
         end
         S_CSTART: begin
            state_in = S_CWAIT;
         end
         S_CWAIT: begin
            if (cdone) begin
               case (cop_ff)
                  OP_ROLL: begin
                     roll_in  = cz_out;
                     cop_in   = OP_PITCH;
                     state_in = S_CSTART;
                  end
                  OP_PITCH: begin
                     pitch_in = cz_out;
                     cop_in   = OP_SC_PITCH;
                     state_in = S_CSTART;
                  end
                  OP_SC_PITCH: begin
                     cp_in    = 32'(cx_out);
                     sp_in    = 32'(cy_out);
                     cop_in   = OP_SC_ROLL;
                     state_in = S_CSTART;
                  end
                  OP_SC_ROLL: begin
                     cr_in    = 32'(cx_out);
                     sr_in    = 32'(cy_out);
                     mstep_in = M_SRSP;
                     phase_in = 1'b0;
                     state_in = S_MUL;
                  end
                  default: begin
                     hq_in    = cz_out;
                     state_in = S_HCALC;
                  end
               endcase
            end
         end
         S_HCALC: begin
            // Round half up, then wrap into 0 to under 360 degrees.
            if (hv < 0) begin
               hv = hv + FULL;
            end
            if (hv >= FULL) begin
               hv = hv - FULL;
            end
            h_in     = hv;
            phase_in = 1'b0;
            mstep_in = M_GMS;
            state_in = seed_ff ? S_FIN : S_MUL;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (seed_ff) begin
                  gacc_in = 32'(h_ff) <<< 8;
                  facc_in = 32'(h_ff) <<< 8;
               end else begin
                  gacc_in = sat32(64'(gacc_ff) + 64'(d_ff));
                  facc_in = fz_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {gacc_in[31:8], facc_in[31:8], 16'(h_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cop_ff       <= OP_ROLL;
         mstep_ff     <= M_AYY;
         phase_ff     <= 1'b0;
         gacc_ff      <= '0;
         facc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cop_ff       <= cop_in;
         mstep_ff     <= mstep_in;
         phase_ff     <= phase_in;
         gacc_ff      <= gacc_in;
         facc_ff      <= facc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         ax_ff   <= req_tdata[15:0];
         ayn_ff  <= -17'(signed'(req_tdata[31:16]));
         az_ff   <= req_tdata[47:32];
         mx_ff   <= 18'(signed'(req_tdata[63:48])) - 18'(off_x_ff);
         my_ff   <= 18'(off_y_ff) - 18'(signed'(req_tdata[79:64]));
         mz_ff   <= 18'(signed'(req_tdata[95:80])) - 18'(off_z_ff);
         gz_ff   <= req_tdata[111:96];
         ms_ff   <= req_tdata[127:112];
         seed_ff <= req_tuser;
      end
      prod_ff     <= prod_full[63:0];
      acc_ff      <= acc_in;
      sqn_ff      <= sqn_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      r_ff        <= r_in;
      roll_ff     <= roll_in;
      pitch_ff    <= pitch_in;
      hq_ff       <= hq_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      cr_ff       <= cr_in;
      sr_ff       <= sr_in;
      ssp_ff      <= ssp_in;
      scp_ff      <= scp_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      h_ff        <= h_in;
      d_ff        <= d_in;
      fz_ff       <= fz_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_MUL && mstep_ff == M_AYY)
      else $error("accepted request did not start the multiply program");
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> h_ff >= 0 && h_ff < FULL)
      else $error("compass heading out of range");
   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside the finish step");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> mstep_ff <= M_FH)
      else $error("multiply program ran past its last step");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heading fusion unit testbench
// Streams sensor requests into the unit and compares every result with an
// in-bench model of the CORDIC compass, the gyro integrator and the
// complementary filter. Runs through several offset and blend settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITERS = 16;
   localparam int FRAC = 7;
   localparam int TAB_N = 24;
   localparam longint INV_GAIN_Q30 = 652032874;
   localparam longint GYRO_SCALE = 8590484;
   localparam int STALL_LIMIT = 20000;

   // Register indexes on the configuration port.
   localparam int REG_OFF_X = 0;
   localparam int REG_OFF_Y = 1;
   localparam int REG_OFF_Z = 2;
   localparam int REG_BLEND = 3;

   typedef struct packed {
      logic        seed;
      logic [15:0] elapsed_ms;
      logic [15:0] gyro_z;
      logic [15:0] mag_z;
      logic [15:0] mag_y;
      logic [15:0] mag_x;
      logic [15:0] accel_z;
      logic [15:0] accel_y;
      logic [15:0] accel_x;
   } sample_t;

   typedef struct packed {
      logic [23:0] gyro_heading;
      logic [23:0] fused_heading;
      logic [15:0] compass_heading;
   } heading_t;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [127:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [3:0]    csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   sample_t  pending_samples[$];
   heading_t expected_headings[$];
   sample_t  cur_sample;
   logic     sample_taken;
   logic     steady_flow;
   int       fail_count;
   int       quiet_cycles;

   // Model copy of the registers and the two heading accumulators.
   longint off_x, off_y, off_z, blend_w;
   longint fused_acc, gyro_acc;

   tilt_compensated_heading_fusion_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint atan_step(input int i);
      longint tab[TAB_N] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tab[i];
   endfunction

   // Vectoring CORDIC: angle of (x, y) in 1/65536 degree.
   function automatic longint angle_of(input longint y, input longint x);
      longint z, t, nx, ny;
      longint lim;
      z = 0;
      lim = longint'(1) << 40;
      if (x == 0 && y == 0) return 0;
      while ((x < 0 ? -x : x) < lim && (y < 0 ? -y : y) < lim) begin
         x = x * 2;
         y = y * 2;
      end
      // Fold the left half-plane onto the right one first.
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 90 * 65536;
         end else begin
            x = -y; y = t; z = -90 * 65536;
         end
      end
      for (int i = 0; i < ITERS && i < TAB_N; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   // Rotation CORDIC: cosine and sine in Q2.30.
   task automatic cos_sin(input longint z, output longint c, output longint s);
      longint x, y, nx, ny;
      x = INV_GAIN_Q30;
      y = 0;
      for (int i = 0; i < ITERS && i < TAB_N; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
         end
         x = nx;
         y = ny;
      end
      c = x;
      s = y;
   endtask

   function automatic longint int_sqrt(input longint n);
      longint res, b;
      res = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Advances the model by one sample and returns the headings it reports.
   task automatic fuse_heading(input sample_t s, output heading_t r);
      longint ax, ay, az, mx, my, mz, gz, ms;
      longint roll, pitch, rad, cp, sp, cr, sr, bx, by, hq, h, d, acc;
      longint full;
      ax = longint'($signed(s.accel_x));
      ay = -longint'($signed(s.accel_y));
      az = longint'($signed(s.accel_z));
      mx = longint'($signed(s.mag_x)) - off_x;
      my = -(longint'($signed(s.mag_y)) - off_y);
      mz = longint'($signed(s.mag_z)) - off_z;
      gz = longint'($signed(s.gyro_z));
      ms = longint'(s.elapsed_ms);
      full = longint'(360) << FRAC;

      roll = angle_of(ay, az < 0 ? -az : az);
      rad = int_sqrt((ay * ay + az * az) << 16);
      pitch = angle_of(-ax * 256, rad);
      cos_sin(pitch, cp, sp);
      cos_sin(roll, cr, sr);

      if (mx == 0 && my == 0 && mz == 0) begin
         hq = 0;
      end else begin
         bx = mx * cp + mz * sp;
         by = mx * ((sr * sp) >>> 30) + my * cr - mz * ((sr * cp) >>> 30);
         hq = angle_of(-by, bx);
      end
      h = (hq + (longint'(1) << (15 - FRAC))) >>> (16 - FRAC);
      if (h < 0) h += full;
      if (h >= full) h -= full;

      if (s.seed) begin
         gyro_acc = h * 256;
         fused_acc = h * 256;
      end else begin
         d = (-gz * ms * GYRO_SCALE + (longint'(1) << 24)) >>> 25;
         gyro_acc = clamp32(gyro_acc + d);
         acc = blend_w * (fused_acc + d) + (65536 - blend_w) * (h * 256) + 32768;
         fused_acc = clamp32(acc >>> 16);
      end
      r.compass_heading = h[15:0];
      r.fused_heading = 24'(fused_acc >>> 8);
      r.gyro_heading = 24'(gyro_acc >>> 8);
   endtask

   // Request driver: presents the next pending sample once the current one
   // has been taken, idling now and then unless a steady stretch is running.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || sample_taken) begin
         if (pending_samples.size() > 0 && (steady_flow || $urandom_range(99) >= 19)) begin
            cur_sample = pending_samples.pop_front();
            req_tdata <= {cur_sample.elapsed_ms, cur_sample.gyro_z, cur_sample.mag_z,
                          cur_sample.mag_y, cur_sample.mag_x, cur_sample.accel_z,
                          cur_sample.accel_y, cur_sample.accel_x};
            req_tuser <= cur_sample.seed;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= steady_flow || $urandom_range(99) >= 19;
   end

   // Monitor: the model steps on each accepted request, and each accepted
   // result is checked against the oldest expected one.
   always @(posedge clock) begin
      heading_t want, got;
      sample_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         fuse_heading(cur_sample, want);
         expected_headings.push_back(want);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_headings.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_headings.pop_front();
            if (got.compass_heading !== want.compass_heading) begin
               $error("compass_heading expected %0d got %0d",
                      want.compass_heading, got.compass_heading);
               fail_count++;
            end
            if (got.fused_heading !== want.fused_heading) begin
               $error("fused_heading expected %0d got %0d",
                      $signed(want.fused_heading), $signed(got.fused_heading));
               fail_count++;
            end
            if (got.gyro_heading !== want.gyro_heading) begin
               $error("gyro_heading expected %0d got %0d",
                      $signed(want.gyro_heading), $signed(got.gyro_heading));
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL tilt_compensated_heading_fusion_unit");
            $finish;
         end
      end
   end

   // Register write with a setup phase and an access phase; the model copy follows it.
   task automatic write_reg(input int idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 4'(idx * 4);
      csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_OFF_X: off_x = longint'($signed(value));
         REG_OFF_Y: off_y = longint'($signed(value));
         REG_OFF_Z: off_z = longint'($signed(value));
         REG_BLEND: blend_w = longint'(value);
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [15:0] ox, input logic [15:0] oy,
                          input logic [15:0] oz, input logic [15:0] w);
      write_reg(REG_OFF_X, ox);
      write_reg(REG_OFF_Y, oy);
      write_reg(REG_OFF_Z, oz);
      write_reg(REG_BLEND, w);
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || expected_headings.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic sample_t rand_sample();
      sample_t s;
      s = 129'({$urandom, $urandom, $urandom, $urandom, $urandom});
      case ($urandom_range(9))
         0: s.elapsed_ms = 16'($urandom_range(20));
         1: begin
            // Field close to or exactly at the hard-iron offsets.
            s.mag_x = 16'(off_x + $urandom_range(2) - 1);
            s.mag_y = 16'(off_y + $urandom_range(2) - 1);
            s.mag_z = 16'(off_z + $urandom_range(2) - 1);
         end
         2: begin
            s.accel_x = 16'($urandom_range(7)); s.accel_y = 16'($urandom_range(3));
            s.accel_z = 16'($urandom_range(3));
         end
         default: ;
      endcase
      s.seed = ($urandom_range(99) < 4);
      return s;
   endfunction

   task automatic push_sample(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az, input logic [15:0] mx,
                              input logic [15:0] my, input logic [15:0] mz,
                              input logic [15:0] gz, input logic [15:0] ms,
                              input logic seed);
      pending_samples.push_back({seed, ms, gz, mz, my, mx, az, ay, ax});
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      steady_flow = 1'b0;
      fail_count = 0;
      off_x = -679;
      off_y = -541;
      off_z = -517;
      blend_w = 64225;
      fused_acc = 0;
      gyro_acc = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset settings: level sensor, zero vectors,
      // a field equal to the offsets, extremes, seeding and saturation.
      push_sample(0, 0, 16384, 200, 0, 0, 0, 10, 0);
      push_sample(0, 0, 0, 200, 300, 0, 0, 10, 0);
      push_sample(16'h7FFF, 0, 0, 0, 16'h7FFF, 0, 0, 10, 0);
      push_sample(16'hFD59, 16'hFDE3, 16'hFDFB, 16'hFD59, 16'hFDE3, 16'hFDFB, 0, 10, 0);
      push_sample(0, 0, 16384, 16'hFD59, 16'hFDE3, 16'hFDFB, 0, 10, 1);
      push_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h8000, 16'hFFFF, 0);
      push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'hFFFF, 0);
      push_sample(100, 16'hFF00, 16'hC000, 16'h8000, 0, 16'h7FFF, 0, 0, 0);
      push_sample(0, 0, 16384, 1000, 0, 0, 0, 0, 1);
      repeat (6) push_sample(0, 0, 16384, 1000, 0, 0, 16'h8000, 16'hFFFF, 0);
      repeat (6) push_sample(0, 0, 16384, 1000, 0, 0, 16'h7FFF, 16'hFFFF, 0);
      push_sample(0, 0, 16384, 16'hFD58, 16'hFDE3, 16'hFDFB, 16'h0001, 1, 0);
      drain();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: ;
            1: set_all(16'h8000, 16'h8000, 16'h8000, 16'd0);
            2: set_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
            3: set_all(16'd0, 16'd0, 16'd0, 16'd32768);
            default: set_all($urandom, $urandom, $urandom, $urandom);
         endcase
         steady_flow = (phase == 3);
         for (int n = 0; n < 320; n++) pending_samples.push_back(rand_sample());
         drain();
      end
      steady_flow = 1'b0;

      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_headings.size() == 0) begin
         $display("PASS tilt_compensated_heading_fusion_unit");
      end else begin
         $display("FAIL tilt_compensated_heading_fusion_unit");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/thcf_pkg.sv
hw/rtl/thcf_cordic.sv
hw/rtl/tilt_compensated_heading_fusion_unit.sv
test/tb.sv
